// File: hdl/linear_probe_hash_table_core_defines.svh
// assertion macros shared by the hash table rtl
// depends on a clock named i_clk and an active-low reset named i_rst_n in the using module
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

// condition in this cycle implies check in this cycle
`define LPHT_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (check)) \
        else $error(msg);

// condition in this cycle implies check in the next cycle
`define LPHT_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

// File: hdl/lpht_pkg.sv
// types and constants for the linear probing hash table
// no dependencies
package lpht_pkg;

    localparam int KEY_W       = 27;
    localparam int TSIZE_W     = 11;
    localparam int SLOT_OUT_W  = 10;
    localparam int COUNT_W     = 11;
    localparam int SLOTS_DEFAULT = 1024;
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1024;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
    } t_lpht_in;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [COUNT_W-1:0]    collision_count;
        logic [KEY_W-1:0]      stored_key;
    } t_lpht_out;

endpackage

// File: hdl/linear_probe_hash_table_core.sv
// open-addressing hash table with linear probing, single module
// depends on lpht_pkg and linear_probe_hash_table_core_defines.svh
// Usage:
//   input channel (i_in_valid/o_in_ready/i_in_data) takes one insert or search command.
//   output channel (o_out_valid/i_out_ready/o_out_data) gives exactly one result per command.
//   config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes table_size, always ready;
//   write it only while no command is in flight.
// Steps of one command, from the input transfer to the result register:
//   the remainder step (one key bit a cycle through the shared subtractor), then
//   1 up to table size probes, each a registered read of the slot memory and its check.
//   o_in_ready is high only while the sequencer is idle, so a new command is taken
//   only once the previous result has moved to the output register.
// Reset: synchronous, active low. table_size goes to 1024 and then a clearing pass
//   writes zero to all SLOTS entries, one a cycle (SLOTS is 1024 by default),
//   with o_in_ready low until it ends.
// Stall: the result sits in an output register; a new command may be taken while
//   it waits. A finished command whose result register is still full holds in a
//   done state until the receiver takes the older result.
`include "linear_probe_hash_table_core_defines.svh"

module linear_probe_hash_table_core #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lpht_pkg::t_lpht_in            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lpht_pkg::t_lpht_out           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpht_pkg::TSIZE_W-1:0]  i_cfg_data
);
    import lpht_pkg::*;

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OPW   = TSIZE_W + 1;
    localparam int BIT_W = $clog2(KEY_W);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [TSIZE_W-1:0] r_table_size;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_cmd, n_cmd;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [TSIZE_W-1:0] r_m, n_m;
    logic [TSIZE_W-1:0] r_rem, n_rem;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [AW-1:0]      r_pos, n_pos;
    logic [COUNT_W-1:0] r_count, n_count;
    t_lpht_out          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_lpht_out          r_out, n_out;
    logic [KEY_W-1:0]   r_rd;

    logic [KEY_W-1:0]   mem [SLOTS];
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [KEY_W-1:0]   mem_wdata;

    logic [TSIZE_W-1:0] m_eff;
    logic [OPW-1:0]     sub_a;
    logic [OPW:0]       sub_diff;
    logic               sub_borrow;
    logic [COUNT_W-1:0] count_inc;
    logic [31:0]        pos_wide;
    logic               in_xfer;
    logic               out_xfer;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_out_valid && i_out_ready;

    // size zero acts as one, sizes past the memory act as the memory depth
    always_comb begin
        if (r_table_size == '0) begin
            m_eff = TSIZE_W'(1);
        end else if (32'(r_table_size) > 32'(SLOTS)) begin
            m_eff = TSIZE_W'(SLOTS);
        end else begin
            m_eff = r_table_size;
        end
    end

    // shared subtractor: remainder steps, then probe wrap check
    always_comb begin
        if (r_state == S_MOD) begin
            sub_a = {r_rem, r_key[r_bit]};
        end else begin
            sub_a = OPW'(r_pos) + OPW'(1);
        end
        sub_diff   = {1'b0, sub_a} - {2'b00, r_m};
        sub_borrow = sub_diff[OPW];
    end

    assign count_inc = r_count + COUNT_W'(1);
    assign pos_wide  = 32'(r_pos);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_m         = r_m;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_pos       = r_pos;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_addr    = r_pos;
        mem_wdata   = r_key;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (32'(r_clr) == 32'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd   = i_in_data.command;
                    n_key   = i_in_data.key;
                    n_m     = m_eff;
                    n_rem   = '0;
                    n_bit   = BIT_W'(KEY_W - 1);
                    n_count = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_rem = sub_borrow ? sub_a[TSIZE_W-1:0] : sub_diff[TSIZE_W-1:0];
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_pos   = AW'(n_rem);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_rd == '0) begin
                    n_res.collision_count = r_count;
                    n_res.stored_key      = '0;
                    if (r_cmd == CMD_SEARCH) begin
                        n_res.status     = ST_NOT_FOUND;
                        n_res.slot_index = '0;
                    end else begin
                        mem_we           = 1'b1;
                        n_res.status     = ST_INSERTED;
                        n_res.slot_index = pos_wide[SLOT_OUT_W-1:0];
                    end
                    n_state = S_DONE;
                end else if (r_cmd == CMD_SEARCH && r_rd == r_key) begin
                    n_res.status          = ST_FOUND;
                    n_res.slot_index      = pos_wide[SLOT_OUT_W-1:0];
                    n_res.collision_count = r_count;
                    n_res.stored_key      = r_rd;
                    n_state               = S_DONE;
                end else begin
                    n_count = count_inc;
                    if (count_inc == r_m) begin
                        // a whole cycle of probes without an end
                        n_res.status          = (r_cmd == CMD_SEARCH) ? ST_NOT_FOUND : ST_FULL;
                        n_res.slot_index      = '0;
                        n_res.collision_count = count_inc;
                        n_res.stored_key      = '0;
                        n_state               = S_DONE;
                    end else begin
                        n_pos   = sub_borrow ? AW'(sub_a) : '0;
                        n_state = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_table_size <= TSIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_m     <= n_m;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_pos   <= n_pos;
        r_count <= n_count;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // slot memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rd <= mem[r_pos];
    end

    `LPHT_ASSERT_NEXT(a_accept_starts_mod, in_xfer, r_state == S_MOD,
        "accepted command did not start the remainder step")
    `LPHT_ASSERT_NOW(a_count_below_size, r_state == S_READ || r_state == S_CHECK,
        r_count < r_m, "probe count reached the table size while probing")
    `LPHT_ASSERT_NOW(a_pos_in_range, r_state == S_READ || r_state == S_CHECK,
        32'(r_pos) < 32'(r_m), "probe position outside the table")
    `LPHT_ASSERT_NOW(a_full_only_insert, r_state == S_DONE && r_res.status == ST_FULL,
        r_cmd == CMD_INSERT, "table full reported for a search")
    `LPHT_ASSERT_NEXT(a_done_loads_output,
        r_state == S_DONE && (!r_out_valid || i_out_ready),
        r_out_valid && r_state == S_IDLE, "finished result not moved to output register")

endmodule

// File: test/tb.sv
// testbench for linear_probe_hash_table_core: directed table, then random insert/search phases
// across many table sizes, each result checked against an in-bench model of the slot store
// or, for three directed rows, a fixed expected result; depends on lpht_pkg and the core rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int NUM_SLOTS    = SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS = 750;
    localparam int CFG_SETTLE   = 8;
    localparam int END_SETTLE   = 100;

    typedef enum {ROW_ITEM, ROW_SIZE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [TSIZE_W-1:0] size;
        logic               cmd;
        logic [KEY_W-1:0]   key;
        bit                 typed;
        t_lpht_out          want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_lpht_in           in_data = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [TSIZE_W-1:0] cfg_data = TSIZE_RESET;
    logic               o_in_ready;
    logic               o_out_valid;
    t_lpht_out          o_out_data;
    logic               o_cfg_ready;

    // model state
    logic [KEY_W-1:0]   slot_store [NUM_SLOTS];
    logic [TSIZE_W-1:0] size_reg;

    t_lpht_out          pending_results [$];
    logic [KEY_W-1:0]   stored_keys [$];
    t_dir_row           dir_rows [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 burst_left = 0;

    linear_probe_hash_table_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(100_000_000);
        $display("[linear_probe_hash_table_core] ERROR");
        $finish;
    end

    function automatic t_lpht_out mk_result(input logic [1:0] st, input int unsigned slot,
                                            input int unsigned hops, input logic [KEY_W-1:0] k);
        t_lpht_out r;
        r.status          = st;
        r.slot_index      = slot[SLOT_OUT_W-1:0];
        r.collision_count = hops[COUNT_W-1:0];
        r.stored_key      = k;
        return r;
    endfunction

    // probe the model store; inserts update it
    function automatic t_lpht_out hash_lookup(input logic cmd, input logic [KEY_W-1:0] key);
        int unsigned m;
        int unsigned pos;
        int unsigned hops;
        m = (size_reg == 0) ? 1 : ((size_reg > NUM_SLOTS) ? NUM_SLOTS : size_reg);
        pos = key % m;
        hops = 0;
        while (hops < m) begin
            if (slot_store[pos] == '0) begin
                if (cmd == CMD_SEARCH) begin
                    return mk_result(ST_NOT_FOUND, 0, hops, '0);
                end
                slot_store[pos] = key;
                return mk_result(ST_INSERTED, pos, hops, '0);
            end
            if (cmd == CMD_SEARCH && slot_store[pos] == key) begin
                return mk_result(ST_FOUND, pos, hops, key);
            end
            hops++;
            pos++;
            if (pos >= m) begin
                pos = 0;
            end
        end
        return mk_result((cmd == CMD_SEARCH) ? ST_NOT_FOUND : ST_FULL, 0, m, '0);
    endfunction

    function automatic void add_item(input logic cmd, input logic [KEY_W-1:0] key);
        dir_rows.push_back('{ROW_ITEM, '0, cmd, key, 1'b0, '0});
    endfunction

    function automatic void add_known(input logic cmd, input logic [KEY_W-1:0] key,
                                      input t_lpht_out want);
        dir_rows.push_back('{ROW_ITEM, '0, cmd, key, 1'b1, want});
    endfunction

    function automatic void add_size(input logic [TSIZE_W-1:0] v);
        dir_rows.push_back('{ROW_SIZE, v, CMD_INSERT, '0, 1'b0, '0});
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return KEY_W'($urandom);
            3, 4, 5: return KEY_W'($urandom_range(1, 2048));
            default: return KEY_W'($urandom_range(1, 99999999));
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic idle(input int n);
        @(negedge i_clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // bursts of random length separated by random gaps, some bursts long
    task automatic pace();
        if (burst_left == 0) begin
            idle($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key, input bit typed,
                             input t_lpht_out want);
        t_lpht_out predicted;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, key: key};
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = hash_lookup(cmd, key);
        pending_results.push_back(typed ? want : predicted);
        if (cmd == CMD_INSERT && key != '0) begin
            stored_keys.push_back(key);
        end
    endtask

    // size changes only once the core has drained
    task automatic write_size(input logic [TSIZE_W-1:0] v);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        size_reg = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_lpht_out want;
        if (i_rst_n && o_out_valid === 1'b1 && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending, status %0d",
                                        o_out_data.status));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    note_mismatch($sformatf("status %0d, want %0d",
                                            o_out_data.status, want.status));
                if (o_out_data.slot_index !== want.slot_index)
                    note_mismatch($sformatf("slot_index %0d, want %0d",
                                            o_out_data.slot_index, want.slot_index));
                if (o_out_data.collision_count !== want.collision_count)
                    note_mismatch($sformatf("collision_count %0d, want %0d",
                                            o_out_data.collision_count, want.collision_count));
                if (o_out_data.stored_key !== want.stored_key)
                    note_mismatch($sformatf("stored_key %0d, want %0d",
                                            o_out_data.stored_key, want.stored_key));
            end
        end
    end

    // receiver stall pattern, with one long hold-off so the core backs up
    always @(negedge i_clk) begin : result_stall
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        static int mode = 0;
        static int mode_left = 0;
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 200) begin
            hold_done = 1'b1;
            hold_left = 600;
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    initial begin : stimulus
        int sent;
        int phase_items;
        logic [TSIZE_W-1:0] next_size;
        logic cmd;
        logic [KEY_W-1:0] key;

        size_reg = TSIZE_RESET;
        foreach (slot_store[i]) slot_store[i] = '0;

        // directed part, default size 1024 after reset
        add_known(CMD_SEARCH, 1, mk_result(ST_NOT_FOUND, 0, 0, '0));
        add_known(CMD_INSERT, '1, mk_result(ST_INSERTED, 1023, 0, '0));
        add_known(CMD_SEARCH, '1, mk_result(ST_FOUND, 1023, 0, '1));
        add_item(CMD_INSERT, 2047);         // wraps past the last slot
        add_item(CMD_INSERT, 0);            // zero key leaves its slot empty
        add_item(CMD_SEARCH, 0);
        add_item(CMD_INSERT, 99999999);
        add_item(CMD_INSERT, 1);
        add_item(CMD_INSERT, 1);            // duplicate lands in next empty slot
        add_item(CMD_SEARCH, 1);
        add_size(0);                        // acts as one slot
        add_item(CMD_INSERT, 5);
        add_item(CMD_SEARCH, 5);
        add_item(CMD_SEARCH, 2047);
        add_size('1);                       // above the slot count
        add_item(CMD_INSERT, 3);
        add_item(CMD_SEARCH, 99999999);
        add_size(4);                        // shrunken table whose slots are already taken
        add_item(CMD_INSERT, 4);
        add_item(CMD_INSERT, 8);
        add_item(CMD_INSERT, 12);
        add_item(CMD_INSERT, 16);
        add_item(CMD_SEARCH, 20);
        add_item(CMD_SEARCH, 4);
        add_size(1024);
        add_item(CMD_SEARCH, 3);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SIZE) begin
                write_size(dir_rows[i].size);
            end else begin
                pace();
                send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random phases, each at its own table size
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       next_size = '0;
                1:       next_size = 1;
                2:       next_size = '1;
                3:       next_size = 1024;
                4:       next_size = $urandom_range(2, 8);
                5:       next_size = $urandom_range(9, 64);
                6:       next_size = $urandom_range(65, 1023);
                default: next_size = $urandom_range(1025, 2046);
            endcase
            write_size(next_size);
            phase_items = $urandom_range(15, 50);
            repeat (phase_items) begin
                cmd = $urandom_range(0, 1) ? CMD_SEARCH : CMD_INSERT;
                if (cmd == CMD_SEARCH && stored_keys.size() != 0 && $urandom_range(0, 9) < 7)
                    key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                else
                    key = rand_key();
                pace();
                send_item(cmd, key, 1'b0, '0);
                sent++;
            end
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("[linear_probe_hash_table_core] OK");
        else
            $display("[linear_probe_hash_table_core] ERROR");
        $finish;
    end

endmodule
